// ===== rtl/lmsfir_pkg.sv =====
// Package for the LMS adaptive FIR filter: field widths, register indexes,
// reset values and the command and status types between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package lmsfir_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int STEP_W       = 16;
	localparam int TAPS_W       = 6;
	localparam int WEIGHT_W     = 32;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int MAX_TAPS_DEF = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_TAPS_IN_USE = CFG_INDEX_W'(1);

	localparam logic [STEP_W-1:0] STEP_SIZE_RST   = STEP_W'(655);
	localparam logic [TAPS_W-1:0] TAPS_IN_USE_RST = TAPS_W'(32);

	typedef struct packed {
		logic start;
		logic issue;
		logic upd_pass;
		logic round;
		logic mul;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

endpackage

// ===== rtl/lmsfir_ctrl.sv =====
// Controller of the LMS adaptive FIR filter: sequences the filter pass and the
// weight update pass over the active taps and owns the output handshake.
// Depends on lmsfir_pkg.
`timescale 1ns / 1ps

module lmsfir_ctrl #(
	parameter int MAX_TAPS = lmsfir_pkg::MAX_TAPS_DEF,
	parameter int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      last_sample,
	input  logic [lmsfir_pkg::TAPS_W-1:0] taps_in_use,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lmsfir_pkg::cmd_t          cmd,
	output logic [TAP_W-1:0]          tap_idx,
	input  lmsfir_pkg::sts_t          sts
);
	import lmsfir_pkg::*;

	localparam int WIDE = TAP_W + TAPS_W;

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_MAC       = 8'b0000_0010,
		ST_MAC_DRAIN = 8'b0000_0100,
		ST_ROUND     = 8'b0000_1000,
		ST_MUL       = 8'b0001_0000,
		ST_UPD       = 8'b0010_0000,
		ST_UPD_DRAIN = 8'b0100_0000,
		ST_FINISH    = 8'b1000_0000
	} state_t;

	state_t state_q, state_next;
	logic [TAP_W-1:0] tap_q;
	logic [TAP_W-1:0] last_tap_q;
	logic [TAP_W-1:0] last_tap_in;
	logic [WIDE-1:0] taps_wide;
	logic last_q;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign tap_idx  = tap_q;

	always_comb begin
		taps_wide = WIDE'(taps_in_use);
		if (taps_wide == '0) begin
			last_tap_in = '0;
		end else if (taps_wide > WIDE'(MAX_TAPS)) begin
			last_tap_in = TAP_W'(MAX_TAPS - 1);
		end else begin
			last_tap_in = TAP_W'(taps_wide - 1'b1);
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					state_next = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				if (tap_q == last_tap_q) begin
					state_next = ST_MAC_DRAIN;
				end
			end
			ST_MAC_DRAIN: begin
				if (!sts.busy) begin
					state_next = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_next = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_next = ST_UPD;
			end
			ST_UPD: begin
				cmd.issue = 1'b1;
				cmd.upd_pass = 1'b1;
				if (tap_q == last_tap_q) begin
					state_next = ST_UPD_DRAIN;
				end
			end
			ST_UPD_DRAIN: begin
				if (!sts.busy) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear = last_q;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q <= '0;
			last_tap_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				last_tap_q <= last_tap_in;
				last_q <= last_sample;
			end
			if (cmd.issue) begin
				tap_q <= (tap_q == last_tap_q) ? '0 : tap_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lmsfir_dp.sv =====
// Datapath of the LMS adaptive FIR filter: weight and history memories, the
// shared multiply-accumulate pipeline, rounding, error scaling and the output register.
// Depends on lmsfir_pkg.
`timescale 1ns / 1ps

module lmsfir_dp #(
	parameter int MAX_TAPS = lmsfir_pkg::MAX_TAPS_DEF,
	parameter int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lmsfir_pkg::cmd_t                       cmd,
	input  logic [TAP_W-1:0]                       tap_idx,
	output lmsfir_pkg::sts_t                       sts,
	input  logic signed [lmsfir_pkg::SAMPLE_W-1:0] noisy_sample,
	input  logic signed [lmsfir_pkg::SAMPLE_W-1:0] desired_sample,
	input  logic [lmsfir_pkg::STEP_W-1:0]          step_size,
	output logic signed [lmsfir_pkg::SAMPLE_W-1:0] filtered_out
);
	import lmsfir_pkg::*;

	localparam int ERR_W  = SAMPLE_W + 1;
	localparam int MULA_W = 2 * ERR_W;
	localparam int PROD_W = MULA_W + SAMPLE_W;
	localparam int DELTA_W = WEIGHT_W + 1;
	localparam int WSUM_W = WEIGHT_W + 2;
	localparam int ACC_W  = PROD_W + TAP_W;
	localparam logic [TAP_W:0]     DEPTH    = (TAP_W + 1)'(MAX_TAPS);
	localparam logic [TAP_W-1:0]   HEAD_MAX = TAP_W'(MAX_TAPS - 1);
	localparam logic signed [WSUM_W-1:0] W_MAX = WSUM_W'(64'sd2147483647);
	localparam logic signed [WSUM_W-1:0] W_MIN = WSUM_W'(-64'sd2147483648);
	localparam logic signed [ACC_W-1:0]  Y_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0]  Y_MIN = ACC_W'(-32768);

	logic signed [WEIGHT_W-1:0] w_mem [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] h_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0] w_valid_q;
	logic [MAX_TAPS-1:0] h_valid_q;

	logic [TAP_W-1:0] head_q;
	logic [TAP_W-1:0] head_next;
	logic [TAP_W:0]   h_wrap;
	logic [TAP_W-1:0] h_addr;

	logic signed [SAMPLE_W-1:0] d_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic signed [MULA_W-1:0]   mu_e_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic signed [WEIGHT_W-1:0] w_rd_s1;
	logic signed [SAMPLE_W-1:0] x_rd_s1;
	logic wv_s1, hv_s1, vld_s1, upd_s1;
	logic [TAP_W-1:0] tap_s1;

	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [WEIGHT_W-1:0] w_s2;
	logic vld_s2, upd_s2;
	logic [TAP_W-1:0] tap_s2;

	logic signed [DELTA_W-1:0]  delta_s3;
	logic signed [WEIGHT_W-1:0] w_s3;
	logic vld_s3;
	logic [TAP_W-1:0] tap_s3;

	logic signed [WEIGHT_W-1:0] w_eff;
	logic signed [SAMPLE_W-1:0] x_eff;
	logic signed [MULA_W-1:0]   mul_a;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [PROD_W-1:0]   upd_sum;
	logic signed [PROD_W-1:0]   upd_sh;
	logic signed [WSUM_W-1:0]   wsum;
	logic signed [WEIGHT_W-1:0] w_new;
	logic signed [ACC_W-1:0]    rnd_sum;
	logic signed [ACC_W-1:0]    rnd_sh;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic signed [ERR_W-1:0]    err;
	logic signed [ERR_W-1:0]    step_s;
	logic signed [MULA_W-1:0]   mu_e;

	assign head_next = (head_q == HEAD_MAX) ? '0 : head_q + 1'b1;
	assign h_wrap = {1'b0, head_q} + DEPTH - {1'b0, tap_idx};
	assign h_addr = (head_q >= tap_idx) ? (head_q - tap_idx) : h_wrap[TAP_W-1:0];

	assign w_eff = wv_s1 ? w_rd_s1 : '0;
	assign x_eff = hv_s1 ? x_rd_s1 : '0;
	assign mul_a = upd_s1 ? mu_e_q : MULA_W'(w_eff);
	assign mul_p = mul_a * x_eff;

	assign upd_sum = prod_s2 + PROD_W'(1 << 17);
	assign upd_sh  = upd_sum >>> 18;

	always_comb begin
		wsum = WSUM_W'(w_s3) + WSUM_W'(delta_s3);
		if (wsum > W_MAX) begin
			w_new = W_MAX[WEIGHT_W-1:0];
		end else if (wsum < W_MIN) begin
			w_new = W_MIN[WEIGHT_W-1:0];
		end else begin
			w_new = wsum[WEIGHT_W-1:0];
		end
	end

	always_comb begin
		rnd_sum = acc_q + ACC_W'(1 << 27);
		rnd_sh = rnd_sum >>> 28;
		if (rnd_sh > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_W-1:0];
		end else if (rnd_sh < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_W-1:0];
		end else begin
			y_sat = rnd_sh[SAMPLE_W-1:0];
		end
	end

	assign err    = ERR_W'(d_q) - ERR_W'(y_q);
	assign step_s = $signed({1'b0, step_size});
	assign mu_e   = step_s * err;

	assign sts.busy = vld_s1 | vld_s2 | vld_s3;
	assign filtered_out = out_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			h_mem[head_next] <= noisy_sample;
		end
		x_rd_s1 <= h_mem[h_addr];
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			w_mem[tap_s3] <= w_new;
		end
		w_rd_s1 <= w_mem[tap_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_q <= '0;
			h_valid_q <= '0;
			head_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 & upd_s2;
			if (cmd.clear) begin
				w_valid_q <= '0;
				h_valid_q <= '0;
			end else begin
				if (cmd.start) begin
					h_valid_q[head_next] <= 1'b1;
					head_q <= head_next;
				end
				if (vld_s3) begin
					w_valid_q[tap_s3] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wv_s1 <= w_valid_q[tap_idx];
		hv_s1 <= h_valid_q[h_addr];
		upd_s1 <= cmd.upd_pass;
		tap_s1 <= tap_idx;

		prod_s2 <= mul_p;
		w_s2 <= w_eff;
		upd_s2 <= upd_s1;
		tap_s2 <= tap_s1;

		delta_s3 <= upd_sh[DELTA_W-1:0];
		w_s3 <= w_s2;
		tap_s3 <= tap_s2;

		if (cmd.start) begin
			d_q <= desired_sample;
			acc_q <= '0;
		end else if (vld_s2 && !upd_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.round) begin
			y_q <= y_sat;
		end
		if (cmd.mul) begin
			mu_e_q <= mu_e;
		end
		if (cmd.load_out) begin
			out_q <= y_q;
		end
	end

endmodule

// ===== rtl/lms_adaptive_fir.sv =====
// Top level of the LMS adaptive FIR filter: configuration registers and the
// controller and datapath instances.
// Depends on lmsfir_pkg, lmsfir_ctrl and lmsfir_dp.
`timescale 1ns / 1ps

// A single multiply-accumulate pipeline walks the taps one per cycle, once to
// form the output and once more to update the weights. Behind the registered
// memory reads the output walk drains through the product register into the
// accumulator, and the update walk also through the delta register into the
// weight write; rounding and then error scaling run as registered steps between
// the walks. A new item is taken once the previous result sits in the output
// register, so items do not overlap. After an item marked last, weights and
// history read as zero again at once; reset does the same with no clearing pass.
module lms_adaptive_fir #(
	parameter int MAX_TAPS = lmsfir_pkg::MAX_TAPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [lmsfir_pkg::SAMPLE_W-1:0] noisy_sample,
	input  logic signed [lmsfir_pkg::SAMPLE_W-1:0] desired_sample,
	input  logic                                   last_sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [lmsfir_pkg::SAMPLE_W-1:0] filtered_out,
	input  logic                                   cfg_write,
	input  logic [lmsfir_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lmsfir_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lmsfir_pkg::*;

	localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [STEP_W-1:0] step_size_q;
	logic [TAPS_W-1:0] taps_in_use_q;
	cmd_t cmd;
	sts_t sts;
	logic [TAP_W-1:0] tap_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_SIZE_RST;
			taps_in_use_q <= TAPS_IN_USE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STEP_SIZE: begin
					step_size_q <= cfg_data[STEP_W-1:0];
				end
				REG_TAPS_IN_USE: begin
					taps_in_use_q <= cfg_data[TAPS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	lmsfir_ctrl #(
		.MAX_TAPS(MAX_TAPS),
		.TAP_W(TAP_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.last_sample(last_sample),
		.taps_in_use(taps_in_use_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.tap_idx(tap_idx),
		.sts(sts)
	);

	lmsfir_dp #(
		.MAX_TAPS(MAX_TAPS),
		.TAP_W(TAP_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.tap_idx(tap_idx),
		.sts(sts),
		.noisy_sample(noisy_sample),
		.desired_sample(desired_sample),
		.step_size(step_size_q),
		.filtered_out(filtered_out)
	);

endmodule
